@@ hdl/ibc_pkg.sv @@
// Shared types and constants for the index buffer cache policy unit.
// No dependencies; imported by ibc_cmp and index_buffer_cache_policy_unit in this folder.
package ibc_pkg;

    // Request field widths
    localparam int KIND_W = 4;
    localparam int KIND_N = 1 << KIND_W;
    localparam int GEN_W  = 8;
    localparam int CNT_W  = 32;

    // Result field widths
    localparam int WAY_OUT_W = 3;

    // Stream payload widths, packed from the lowest bit up and padded to bytes
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 8;

    // One cache way as held in the entry RAM
    typedef struct packed {
        logic             valid;
        logic [GEN_W-1:0] gen;
        logic [CNT_W-1:0] cnt;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Flags from the shared count comparator
    typedef struct packed {
        logic lt;
        logic eq;
    } cmp_res_t;

endpackage

@@ hdl/ibc_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ibc_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/ibc_cmp.sv @@
// Shared unsigned count comparator: less-than by subtraction, plus equality.
// Depends on ibc_pkg.
module ibc_cmp (
    input  logic [ibc_pkg::CNT_W-1:0] a,
    input  logic [ibc_pkg::CNT_W-1:0] b,
    output ibc_pkg::cmp_res_t         res
);
    import ibc_pkg::*;

    logic [CNT_W:0] diff;

    // Borrow out of a - b means a < b
    assign diff   = {1'b0, a} - {1'b0, b};
    assign res.lt = diff[CNT_W];
    assign res.eq = (a == b);

endmodule

@@ hdl/index_buffer_cache_policy_unit.sv @@
// Index buffer cache policy unit. Holds PRIM_KINDS sets of WAYS ways (valid,
// generator id, element count) in one RAM and, for each request item, decides
// whether a cached entry serves it or which way is refilled. After reset a
// clearing pass writes every entry before the first item is taken. One item at
// a time: each way scanned takes a RAM read and a compare against the request
// and, if that settles nothing, a compare against the smallest count so far, on
// the one shared comparator. An item runs from acceptance through the scan, a
// refill write where needed and the result step before the input is ready again.
// The result sits in an output register, so the next item may enter while it
// waits; that item stalls at its own result step until the register is taken.
module index_buffer_cache_policy_unit #(
    parameter int WAYS       = 8,
    parameter int PRIM_KINDS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // generator_id [7:0], elem_count [39:8], reusable [40], zero [47:41]
    input  logic [ibc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // prim_kind [3:0]
    input  logic [ibc_pkg::KIND_W-1:0]        s_axis_tuser,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // hit [0], way_used [3:1], evicted [4], zero [7:5]
    output logic [ibc_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready
);
    import ibc_pkg::*;

    localparam int DEPTH  = PRIM_KINDS * WAYS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam logic [WAY_W-1:0]  LAST_WAY  = WAY_W'(WAYS - 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    typedef enum logic [2:0] {
        ST_CLR,
        ST_IDLE,
        ST_RD,
        ST_CMPR,
        ST_CMPM,
        ST_WR,
        ST_DONE
    } state_t;

    state_t             state_reg;
    logic [ADDR_W-1:0]  clr_reg;
    logic [ADDR_W-1:0]  base_reg;
    logic [ADDR_W-1:0]  rd_addr_reg;
    logic [WAY_W-1:0]   way_reg;
    logic [GEN_W-1:0]   gen_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               reuse_reg;
    logic               empty_found_reg;
    logic [WAY_W-1:0]   empty_way_reg;
    logic [CNT_W-1:0]   best_cnt_reg;
    logic [WAY_W-1:0]   best_way_reg;
    logic [WAY_W-1:0]   chosen_reg;
    logic               hit_reg;
    logic               evict_reg;
    logic               out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic [ADDR_W-1:0]  base_tbl [KIND_N];
    logic               in_accept;
    logic               out_accept;
    logic               out_load;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    entry_t             ram_wdata;
    entry_t             ram_rdata;
    logic [CNT_W-1:0]   cmp_b;
    cmp_res_t           cmp_res;
    logic               same_gen;
    logic               count_match;
    logic               new_best;
    logic [WAY_W-1:0]   best_way_now;
    logic [WAY_W:0]     way_inc;
    logic [WAY_W+2:0]   chosen_ext;

    // Set base address for every kind code, kind reduced modulo PRIM_KINDS
    for (genvar k = 0; k < KIND_N; k++)
    begin : g_base
        assign base_tbl[k] = ADDR_W'((k % PRIM_KINDS) * WAYS);
    end

    // Entry store
    ibc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_addr_reg),
        .rdata (ram_rdata)
    );

    // Shared comparator: against the request, then against the smallest count
    assign cmp_b = (state_reg == ST_CMPM) ? best_cnt_reg : cnt_reg;

    ibc_cmp u_cmp (
        .a   (ram_rdata.cnt),
        .b   (cmp_b),
        .res (cmp_res)
    );

    // Way decision terms
    assign same_gen     = ram_rdata.valid && (ram_rdata.gen == gen_reg);
    assign count_match  = reuse_reg ? !cmp_res.lt : cmp_res.eq;
    assign new_best     = (way_reg == '0) || cmp_res.lt;
    assign best_way_now = new_best ? way_reg : best_way_reg;
    assign way_inc      = {1'b0, way_reg} + 1'b1;

    // RAM write: clearing pass or refill
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = clr_reg;
        ram_wdata = '0;
        case (state_reg)
            ST_CLR:
            begin
                ram_we = 1'b1;
            end
            ST_WR:
            begin
                ram_we          = 1'b1;
                ram_waddr       = base_reg + ADDR_W'(chosen_reg);
                ram_wdata.valid = 1'b1;
                ram_wdata.gen   = gen_reg;
                ram_wdata.cnt   = cnt_reg;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Handshakes
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_accept    = out_valid_reg && m_axis_tready;
    assign out_load      = (state_reg == ST_DONE) && (!out_valid_reg || m_axis_tready);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign chosen_ext    = {3'b000, chosen_reg};

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLR;
            clr_reg         <= '0;
            base_reg        <= '0;
            rd_addr_reg     <= '0;
            way_reg         <= '0;
            gen_reg         <= '0;
            cnt_reg         <= '0;
            reuse_reg       <= 1'b0;
            empty_found_reg <= 1'b0;
            empty_way_reg   <= '0;
            best_cnt_reg    <= '0;
            best_way_reg    <= '0;
            chosen_reg      <= '0;
            hit_reg         <= 1'b0;
            evict_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_data_reg    <= '0;
        end
        else
        begin
            // Output register: load a finished item, else clear once taken
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_accept)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == LAST_ADDR)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        base_reg        <= base_tbl[s_axis_tuser];
                        rd_addr_reg     <= base_tbl[s_axis_tuser];
                        gen_reg         <= s_axis_tdata[7:0];
                        cnt_reg         <= s_axis_tdata[39:8];
                        reuse_reg       <= s_axis_tdata[40];
                        way_reg         <= '0;
                        empty_found_reg <= 1'b0;
                        hit_reg         <= 1'b0;
                        evict_reg       <= 1'b0;
                        state_reg       <= ST_RD;
                    end
                end
                ST_RD:
                begin
                    state_reg <= ST_CMPR;
                end
                ST_CMPR:
                begin
                    // First same-generator way settles hit or reusable refill
                    if (same_gen && count_match)
                    begin
                        hit_reg    <= 1'b1;
                        chosen_reg <= way_reg;
                        state_reg  <= ST_DONE;
                    end
                    else if (same_gen && reuse_reg)
                    begin
                        evict_reg  <= 1'b1;
                        chosen_reg <= way_reg;
                        state_reg  <= ST_WR;
                    end
                    else
                    begin
                        state_reg <= ST_CMPM;
                    end
                end
                ST_CMPM:
                begin
                    // Track first empty way and smallest count, low way wins ties
                    if (new_best)
                    begin
                        best_cnt_reg <= ram_rdata.cnt;
                        best_way_reg <= way_reg;
                    end
                    if (!ram_rdata.valid && !empty_found_reg)
                    begin
                        empty_found_reg <= 1'b1;
                        empty_way_reg   <= way_reg;
                    end
                    if (way_reg == LAST_WAY)
                    begin
                        if (empty_found_reg)
                        begin
                            chosen_reg <= empty_way_reg;
                        end
                        else if (!ram_rdata.valid)
                        begin
                            chosen_reg <= way_reg;
                        end
                        else
                        begin
                            chosen_reg <= best_way_now;
                            evict_reg  <= 1'b1;
                        end
                        state_reg <= ST_WR;
                    end
                    else
                    begin
                        way_reg     <= way_inc[WAY_W-1:0];
                        rd_addr_reg <= base_reg + ADDR_W'(way_inc);
                        state_reg   <= ST_RD;
                    end
                end
                ST_WR:
                begin
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_load)
                    begin
                        out_data_reg  <= {3'b000, evict_reg, chosen_ext[2:0], hit_reg};
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // A hit never evicts
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[4]))
        else $error("hit reported together with eviction");

    // An accepted item starts with a RAM read of its set
    a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == ST_RD) && (rd_addr_reg == base_reg))
        else $error("accepted item did not start its scan");

    // The scan never runs past the last way
    a_way_bound: assert property (@(posedge clk) disable iff (!rst_n)
        way_reg <= LAST_WAY)
        else $error("way counter out of range");

    // A new result only appears at the end of an item
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the result step");
`endif

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for index_buffer_cache_policy_unit: predicts the per-kind way cache
// (hit, way, eviction) for every accepted request item and compares each result item.
// Depends on hdl/ibc_pkg.sv and hdl/index_buffer_cache_policy_unit.sv.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ibc_pkg::*;

    localparam int NUM_WAYS      = 8;
    localparam int NUM_KINDS     = 16;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 3 * NUM_WAYS + 16;

    // One request item and one result item
    typedef struct packed {
        logic [KIND_W-1:0] prim_kind;
        logic [GEN_W-1:0]  generator_id;
        logic [CNT_W-1:0]  elem_count;
        logic              reusable;
    } lookup_req_t;

    typedef struct packed {
        logic                 hit;
        logic [WAY_OUT_W-1:0] way_used;
        logic                 evicted;
    } lookup_res_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [KIND_W-1:0]     s_axis_tuser = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;

    // Shadow copy of the cache contents
    bit               cache_valid [NUM_KINDS][NUM_WAYS];
    bit [GEN_W-1:0]   cache_gen   [NUM_KINDS][NUM_WAYS];
    bit [CNT_W-1:0]   cache_cnt   [NUM_KINDS][NUM_WAYS];

    lookup_res_t pending_results[$];
    lookup_req_t last_req;
    bit          have_last = 1'b0;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_cycles   = 0;
    int error_count   = 0;
    int results_seen  = 0;
    int requests_sent = 0;
    int hit_total     = 0;
    int evict_total   = 0;

    index_buffer_cache_policy_unit #(
        .WAYS       (NUM_WAYS),
        .PRIM_KINDS (NUM_KINDS)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("tb_top: mismatch: %s", msg);
        error_count++;
    endtask

    // Policy: scan for a same-generator way, else first empty way, else smallest count
    function automatic lookup_res_t predict_lookup(input lookup_req_t req);
        int          kind;
        int          way;
        int          pick;
        bit          done;
        bit          match;
        lookup_res_t res;
        kind = int'(req.prim_kind) % NUM_KINDS;
        res  = '0;
        done = 1'b0;
        pick = 0;
        for (way = 0; way < NUM_WAYS && !done; way++)
        begin
            if (cache_valid[kind][way] && cache_gen[kind][way] == req.generator_id)
            begin
                match = req.reusable ? (cache_cnt[kind][way] >= req.elem_count)
                                     : (cache_cnt[kind][way] == req.elem_count);
                if (match)
                begin
                    res.hit = 1'b1;
                    pick    = way;
                    done    = 1'b1;
                end
                else if (req.reusable)
                begin
                    // larger buffer needed: drop this entry and refill in place
                    res.evicted = 1'b1;
                    pick        = way;
                    done        = 1'b1;
                end
            end
        end
        if (!done)
        begin
            pick = -1;
            for (way = 0; way < NUM_WAYS; way++)
                if (!cache_valid[kind][way] && pick < 0)
                    pick = way;
            if (pick < 0)
            begin
                // set full: smallest count loses, lowest way on a tie
                pick = 0;
                for (way = 1; way < NUM_WAYS; way++)
                    if (cache_cnt[kind][way] < cache_cnt[kind][pick])
                        pick = way;
                res.evicted = 1'b1;
            end
        end
        if (!res.hit)
        begin
            cache_valid[kind][pick] = 1'b1;
            cache_gen[kind][pick]   = req.generator_id;
            cache_cnt[kind][pick]   = req.elem_count;
        end
        res.way_used = pick[WAY_OUT_W-1:0];
        return res;
    endfunction

    function automatic lookup_req_t make_req(input int kind, input int gen,
                                             input logic [CNT_W-1:0] cnt, input bit reuse);
        lookup_req_t req;
        req.prim_kind    = kind[KIND_W-1:0];
        req.generator_id = gen[GEN_W-1:0];
        req.elem_count   = cnt;
        req.reusable     = reuse;
        return req;
    endfunction

    // Few kinds and generators so sets fill up; repeats of the last item give hits
    function automatic lookup_req_t random_request();
        lookup_req_t req;
        if (have_last && $urandom_range(99) < 20)
        begin
            req          = last_req;
            req.reusable = 1'($urandom_range(1));
            if ($urandom_range(1) != 0)
                req.elem_count = last_req.elem_count >> 1;
            return req;
        end
        req.prim_kind    = ($urandom_range(99) < 70) ? KIND_W'($urandom_range(2))
                                                     : KIND_W'($urandom_range(NUM_KINDS - 1));
        req.generator_id = ($urandom_range(99) < 85) ? GEN_W'($urandom_range(11))
                                                     : GEN_W'($urandom_range(255));
        case ($urandom_range(9))
            0, 1, 2, 3: req.elem_count = $urandom_range(15);
            4:          req.elem_count = '0;
            5:          req.elem_count = '1;
            default:    req.elem_count = $urandom();
        endcase
        req.reusable = 1'($urandom_range(1));
        return req;
    endfunction

    // Offer one item from a rising edge; returns at the edge that accepts it
    task automatic send_request(input lookup_req_t req);
        lookup_res_t res;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tdata  <= IN_DATA_W'({req.reusable, req.elem_count, req.generator_id});
        s_axis_tuser  <= req.prim_kind;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (s_axis_tready !== 1'b1);
        res = predict_lookup(req);
        pending_results.push_back(res);
        last_req  = req;
        have_last = 1'b1;
        requests_sent++;
        hit_total   += int'(res.hit);
        evict_total += int'(res.evicted);
    endtask

    // Stop offering and wait for every outstanding result, then let the block settle
    task automatic drain_results();
        int waited;
        s_axis_tvalid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_results.size() != 0)
        begin
            report_mismatch($sformatf("%0d result items never arrived", pending_results.size()));
            pending_results.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Receiver: random stalls, or a long hold-off when one is requested
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_cycles   <= hold_cycles - 1;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Compare each accepted result item with the oldest prediction
    always @(posedge clk)
    begin
        lookup_res_t want;
        if (rst_n && m_axis_tvalid === 1'b1 && m_axis_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("unexpected result item 0x%02h", m_axis_tdata));
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tdata[0] !== want.hit)
                    report_mismatch($sformatf("result %0d hit: got %b, want %b",
                                              results_seen, m_axis_tdata[0], want.hit));
                if (m_axis_tdata[3:1] !== want.way_used)
                    report_mismatch($sformatf("result %0d way_used: got %0d, want %0d",
                                              results_seen, m_axis_tdata[3:1], want.way_used));
                if (m_axis_tdata[4] !== want.evicted)
                    report_mismatch($sformatf("result %0d evicted: got %b, want %b",
                                              results_seen, m_axis_tdata[4], want.evicted));
                if (m_axis_tdata[7:5] !== 3'b000)
                    report_mismatch($sformatf("result %0d padding: got %b",
                                              results_seen, m_axis_tdata[7:5]));
            end
            results_seen++;
        end
    end

    // Every policy path by hand: fills, hits, reusable refill, full-set eviction and tie
    task automatic test_directed();
        send_idle_pct = 0;
        stall_pct     = 0;
        send_request(make_req(0, 1, 32'd100, 1'b0));  // empty way 0
        send_request(make_req(0, 1, 32'd100, 1'b0));  // exact hit
        send_request(make_req(0, 1, 32'd50,  1'b1));  // reusable, larger cached
        send_request(make_req(0, 1, 32'd200, 1'b1));  // reusable, too small: refill way 0
        send_request(make_req(0, 1, 32'd100, 1'b0));  // same generator, no match: way 1
        send_request(make_req(0, 1, 32'd100, 1'b0));  // hit on the second way
        send_request(make_req(0, 2, 32'd0,   1'b0));
        send_request(make_req(0, 3, 32'd300, 1'b0));
        send_request(make_req(0, 4, 32'd40,  1'b0));
        send_request(make_req(0, 5, 32'd40,  1'b0));
        send_request(make_req(0, 6, 32'd500, 1'b0));
        send_request(make_req(0, 7, 32'd600, 1'b0));  // set now full
        send_request(make_req(0, 9, 32'd40,  1'b0));  // smallest count goes
        send_request(make_req(0, 11, 32'd9,  1'b0));  // three-way tie, lowest way
        send_request(make_req(0, 1, 32'd250, 1'b1));  // first same-generator way refilled
        send_request(make_req(15, 255, 32'hFFFF_FFFF, 1'b1));
        send_request(make_req(15, 255, 32'hFFFF_FFFF, 1'b0));
        send_request(make_req(15, 255, 32'd0, 1'b1));
        send_request(make_req(15, 0, 32'd0, 1'b0));
        send_request(make_req(15, 0, 32'd0, 1'b1));
        drain_results();
    endtask

    task automatic test_random(input int count, input int idle_pct, input int stall);
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        repeat (count)
            send_request(random_request());
        drain_results();
    endtask

    // Receiver holds off long enough for the block to back up onto its input
    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct     = 0;
        @(negedge clk);
        hold_cycles = 300;
        @(posedge clk);
        repeat (24)
            send_request(random_request());
        drain_results();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(90, 0, 0);
        test_random(90, 83, 0);
        test_backpressure();
        test_random(90, 0, 83);
        test_random(90, 21, 21);
        $display("tb_top: %0d requests, %0d results checked", requests_sent, results_seen);
        $display("tb_top: %0d hits, %0d evictions, %0d check failures",
                 hit_total, evict_total, error_count);
        if (error_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    // Watchdog
    initial
    begin
        #10_000_000;
        $display("tb_top: errors");
        $finish;
    end

endmodule
